[sv/pnt_pkg.sv]
// Shared constants for the perfect number test block.
// No dependencies; compiled first.
`default_nettype none

package pnt_pkg;

  localparam int VALUE_BITS_DEFAULT = 16;

endpackage

`default_nettype wire

[sv/pnt_channels.sv]
// Valid/ready channel interfaces for the perfect number test block.
// Depends on pnt_pkg for the default value width.
`default_nettype none

interface pnt_value_if
  import pnt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface pnt_result_if;
  logic valid;
  logic ready;
  logic is_perfect;

  modport source (output valid, output is_perfect, input ready);
  modport sink (input valid, input is_perfect, output ready);
endinterface

`default_nettype wire

[sv/perfect_number_test.sv]
// Perfect number test: sums the proper divisors of each value and compares.
// Each item tries candidate divisors d with d*d <= value in turn, each through
// a check step, the bit-serial divider (with its start and done handoff), up to
// two add steps and an advance step; the search stops early once the sum passes
// the value. Values 0 and 1 go straight to the finish step. One result beat per
// input beat; the next value is taken while a result waits.
// Depends on pnt_pkg, pnt_channels and pnt_div.
`default_nettype none

module perfect_number_test
  import pnt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  pnt_value_if.sink    request,
  pnt_result_if.source result
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    DIVIDE,
    ADD_D,
    ADD_Q,
    NEXT,
    FINISH
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] d;
  logic [VALUE_BITS+1:0] sq;
  logic [VALUE_BITS:0]   total;
  logic                  verdict;
  logic                  out_valid;
  logic                  out_perfect;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [VALUE_BITS-1:0] div_rem;

  pnt_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (v),
    .divisor   (d),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign request.ready     = (state == IDLE);
  assign result.valid      = out_valid;
  assign result.is_perfect = out_perfect;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (state == FINISH && (!out_valid || result.ready)) begin
        out_valid   <= 1'b1;
        out_perfect <= verdict;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (request.valid) begin
            v     <= request.value;
            d     <= VALUE_BITS'(2);
            sq    <= (VALUE_BITS + 2)'(4);
            total <= (VALUE_BITS + 1)'(1);
            if (request.value < VALUE_BITS'(2)) begin
              verdict <= 1'b0;
              state   <= FINISH;
            end else begin
              state <= CHECK;
            end
          end
        end
        CHECK: begin
          if (sq > {2'b00, v}) begin
            verdict <= (total == {1'b0, v});
            state   <= FINISH;
          end else begin
            div_start <= 1'b1;
            state     <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (div_done) begin
            state <= (div_rem == '0) ? ADD_D : NEXT;
          end
        end
        ADD_D: begin
          total <= total + {1'b0, d};
          state <= (div_quo != d) ? ADD_Q : NEXT;
        end
        ADD_Q: begin
          total <= total + {1'b0, div_quo};
          state <= NEXT;
        end
        NEXT: begin
          if (total > {1'b0, v}) begin
            verdict <= 1'b0;
            state   <= FINISH;
          end else begin
            sq    <= sq + {1'b0, d, 1'b1};
            d     <= d + 1'b1;
            state <= CHECK;
          end
        end
        FINISH: begin
          if (!out_valid || result.ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/pnt_div.sv]
// Restoring divider, one quotient bit per cycle, used by the divisor search.
// Depends on pnt_pkg for the default width.
`default_nettype none

module pnt_div
  import pnt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [VALUE_BITS-1:0] divisor,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      quotient,
  output logic [VALUE_BITS-1:0]      remainder
);

  localparam int CountBits = $clog2(VALUE_BITS + 1);

  logic                  busy;
  logic [CountBits-1:0]  count;
  logic [VALUE_BITS:0]   rem;
  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] dsr;
  logic [VALUE_BITS:0]   trial;
  logic                  fits;

  assign trial = {rem[VALUE_BITS-1:0], quo[VALUE_BITS-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CountBits'(VALUE_BITS);
        rem   <= '0;
        quo   <= dividend;
        dsr   <= divisor;
      end else if (busy) begin
        if (fits) begin
          rem <= trial - {1'b0, dsr};
          quo <= {quo[VALUE_BITS-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[VALUE_BITS-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CountBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem[VALUE_BITS-1:0];

endmodule

`default_nettype wire

[sim/perfect_number_test_test.sv]
// Testbench for perfect_number_test: drives values through the request channel
// and checks each verdict against a trial-division predictor kept in a scoreboard.
// Depends on pnt_pkg, pnt_channels and the perfect_number_test RTL.
`timescale 1ns / 100ps

import pnt_pkg::*;

class perfect_scoreboard;
  bit          verdict_q[$];
  int unsigned checked;
  int unsigned mismatches;
  int unsigned strays;
  int unsigned perfect_hits;

  function new();
    checked      = 0;
    mismatches   = 0;
    strays       = 0;
    perfect_hits = 0;
  endfunction

  function bit predict_perfect(bit [63:0] raw);
    bit [63:0] v;
    bit [63:0] total;
    bit [63:0] d;
    v = raw & ((64'd1 << VALUE_BITS_DEFAULT) - 64'd1);
    if (v < 64'd2) return 1'b0;
    total = 64'd1;
    for (d = 64'd2; d * d <= v; d++) begin
      if (v % d == 64'd0) begin
        total += d;
        if (v / d != d) total += v / d;
      end
    end
    return total == v;
  endfunction

  function void note_value(bit [63:0] v);
    verdict_q.push_back(predict_perfect(v));
  endfunction

  function void check_verdict(logic actual);
    bit want;
    if (verdict_q.size() == 0) begin
      strays++;
      if (mismatches + strays <= 10)
        $display("%0t: verdict %b arrived with none expected", $realtime, actual);
      return;
    end
    want = verdict_q.pop_front();
    checked++;
    if (want) perfect_hits++;
    if (actual !== want) begin
      mismatches++;
      if (mismatches + strays <= 10)
        $display("%0t: is_perfect mismatch, expected %b, got %b", $realtime, want, actual);
    end
  endfunction

  function int unsigned pending();
    return verdict_q.size();
  endfunction
endclass

module perfect_number_test_test;
  localparam int VALUE_BITS = VALUE_BITS_DEFAULT;
  localparam int RANDOM_ITEMS = 100;

  logic clk;
  logic rst;

  pnt_value_if #(.VALUE_BITS(VALUE_BITS)) value_ch ();
  pnt_result_if verdict_ch ();

  perfect_number_test #(.VALUE_BITS(VALUE_BITS)) DUT (
    .clk     (clk),
    .rst     (rst),
    .request (value_ch),
    .result  (verdict_ch)
  );

  perfect_scoreboard sb;
  int unsigned values_sent = 0;
  int unsigned largest_sent = 0;
  int unsigned burst_left = 0;

  logic [15:0] stall_pat = 16'hA5C3;
  int unsigned rx_cycle = 0;
  logic [1:0]  rx_mode = 2'd0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    value_ch.valid   = 1'b0;
    value_ch.value   = '0;
    verdict_ch.ready = 1'b0;
    rst              = 1'b1;
  end

  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 97 == 0) begin
      rx_mode   <= 2'($urandom_range(0, 3));
      stall_pat <= 16'($urandom);
    end else begin
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    end
    case (rx_mode)
      2'd0: verdict_ch.ready <= 1'b1;
      2'd1: verdict_ch.ready <= stall_pat[0];
      2'd2: verdict_ch.ready <= stall_pat[0] | stall_pat[3];
      default: verdict_ch.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && verdict_ch.valid && verdict_ch.ready) sb.check_verdict(verdict_ch.is_perfect);
  end

  task automatic send_value(input bit [63:0] v);
    @(negedge clk);
    value_ch.valid <= 1'b1;
    value_ch.value <= v[VALUE_BITS-1:0];
    do @(posedge clk); while (!(value_ch.valid && value_ch.ready));
    sb.note_value(v);
    values_sent++;
    if (32'(v[VALUE_BITS-1:0]) > largest_sent) largest_sent = 32'(v[VALUE_BITS-1:0]);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles == 0) return;
    @(negedge clk);
    value_ch.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    if ($urandom_range(0, 4) != 0) idle_sender($urandom_range(1, 6));
  endtask

  task automatic wait_for_verdicts();
    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic bit [63:0] pick_value();
    bit [63:0] perfects [4] = '{64'd6, 64'd28, 64'd496, 64'd8128};
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind <= 3) return 64'($urandom_range(0, 255));
    if (kind <= 5) return perfects[$urandom_range(0, 3)] + 64'($urandom_range(0, 4)) - 64'd2;
    if (kind <= 8) return 64'($urandom_range(0, 65535));
    return 64'(32768 + $urandom_range(0, 32767));
  endfunction

  initial begin
    bit [63:0] directed [$] = '{
      64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd12, 64'd27,
      64'd28, 64'd29, 64'd495, 64'd496, 64'd497, 64'd8127, 64'd8128, 64'd8129,
      64'd65535, 64'd65534, 64'd65521, 64'd65520, 64'd32768, 64'd1, 64'd6
    };
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_value(directed[i]);
    wait_for_verdicts();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_value(pick_value());
      if (n == RANDOM_ITEMS / 2) wait_for_verdicts();
      else pace_sender();
    end

    wait_for_verdicts();
    repeat (100) @(posedge clk);

    $display("Sent %0d values up to %0d; %0d verdicts checked, %0d of them perfect.",
             values_sent, largest_sent, sb.checked, sb.perfect_hits);
    if (sb.mismatches > 10)
      $display("%0d mismatches in total", sb.mismatches);
    if (sb.pending() != 0)
      $display("%0d verdicts never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.strays == 0 && sb.pending() == 0) begin
      $display("perfect_number_test test passed");
    end else begin
      $display("perfect_number_test test failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("perfect_number_test test failed");
    $finish;
  end
endmodule

[perfect_number_test.f]
sv/pnt_pkg.sv
sv/pnt_channels.sv
sv/pnt_div.sv
sv/perfect_number_test.sv
sim/perfect_number_test_test.sv
